@@ sv/mcwd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the multi-client watchdog check-in unit.
// No dependencies; imported by the top level and the testbench.
package mcwd_pkg;

	// Beat layouts
	localparam int OP_W      = 2;
	localparam int CID_W     = 16;
	localparam int STAT_W    = 2;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 8;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_CHECKIN    = 2'd0,
		OP_REGISTER   = 2'd1,
		OP_UNREGISTER = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_NOTFOUND = 2'd2
	} status_t;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

endpackage

@@ sv/multi_client_watchdog_checkin_unit.sv @@
`timescale 1ns / 1ps
// Multi-client watchdog check-in unit: top level with the slot-scan sequencer.
// Depends on mcwd_pkg and mcwd_slot_ram.
//
// Each input beat carries an operation (check in, register, unregister) and a
// client id; exactly one result beat (refresh, status) comes back per input.
// The slot table is scanned one slot per cycle through a single read port and
// one id comparator, so a check-in reads every slot before its result is
// presented; register and unregister stop at the first free or matching slot.
// Unused op code three skips the scan and goes straight to the result. The
// block takes one item at a time: s_tready is high only while the sequencer is
// idle, which it reaches on the cycle the result is presented, so the next
// beat can be taken at the earliest while that result is on the output. A
// result held by m_tready low delays the return to idle only when the next
// result is ready before the previous one has left; a finished result may sit
// in the output register while the next item is taken.
// No clearing pass is needed after reset.
module multi_client_watchdog_checkin_unit
	import mcwd_pkg::*;
#(
	parameter int SLOTS   = 24,
	parameter int ID_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// op [1:0], client_id [17:2], zero fill [23:18]
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// refresh [0], status [2:1], zero fill [7:3]
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	state_t             st_q;
	op_t                op_q;
	logic [ID_BITS-1:0] key_q;
	logic [IW-1:0]      rd_idx_q;
	logic               iss_q;
	logic               iss_s1;
	logic [IW-1:0]      idx_s1;
	logic               done_q;
	logic [SLOTS-1:0]   chk_q;
	logic               res_refresh_q;
	status_t            res_status_q;
	logic               m_tvalid_q;
	logic               out_refresh_q;
	status_t            out_status_q;

	logic [OP_W-1:0]    in_op;
	logic [CID_W-1:0]   in_cid;
	logic [ID_BITS-1:0] cur_id;
	logic               hit;
	logic               free;
	logic               slot_done;
	logic               eval;
	logic               is_last;
	logic               scan_end;
	logic               fin;
	logic               out_load;
	logic               we;
	logic [ID_BITS-1:0] wdata;

	// Input beat unpacking
	assign in_op    = s_tdata[OP_W-1:0];
	assign in_cid   = s_tdata[OP_W+CID_W-1:OP_W];
	assign s_tready = (st_q == ST_IDLE);

	mcwd_slot_ram #(
		.DEPTH(SLOTS),
		.AW   (IW),
		.DW   (ID_BITS)
	) u_slot_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wdata),
		.raddr (rd_idx_q),
		.rdata (cur_id)
	);

	// Per-slot evaluation of the returned read data
	always_comb begin
		eval      = (st_q == ST_SCAN) && iss_s1;
		is_last   = (idx_s1 == LAST_IDX);
		hit       = (cur_id == key_q);
		free      = (cur_id == '0);
		slot_done = free || chk_q[idx_s1] || hit;
		we        = eval && (((op_q == OP_REGISTER) && free) ||
			((op_q == OP_UNREGISTER) && hit));
		wdata     = (op_q == OP_REGISTER) ? key_q : '0;
		case (op_q)
			OP_CHECKIN:    scan_end = is_last;
			OP_REGISTER:   scan_end = free || is_last;
			OP_UNREGISTER: scan_end = hit || is_last;
			default:       scan_end = 1'b1;
		endcase
		fin       = eval && scan_end;
		out_load  = (st_q == ST_FIN) && (!m_tvalid_q || m_tready);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			op_q          <= OP_CHECKIN;
			rd_idx_q      <= '0;
			iss_q         <= 1'b0;
			iss_s1        <= 1'b0;
			idx_s1        <= '0;
			done_q        <= 1'b1;
			chk_q         <= '0;
			res_refresh_q <= 1'b0;
			res_status_q  <= STAT_OK;
			m_tvalid_q    <= 1'b0;
		end else begin
			// read pipeline tag
			iss_s1 <= iss_q;
			idx_s1 <= rd_idx_q;

			// output valid: load a finished result or drop on handshake
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q          <= op_t'(in_op);
						rd_idx_q      <= '0;
						done_q        <= 1'b1;
						res_refresh_q <= 1'b0;
						res_status_q  <= STAT_OK;
						if (in_op == OP_CHECKIN || in_op == OP_REGISTER ||
							in_op == OP_UNREGISTER) begin
							iss_q <= 1'b1;
							st_q  <= ST_SCAN;
						end else begin
							st_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					// issue reads one slot per cycle
					if (iss_q && rd_idx_q != LAST_IDX) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (fin) begin
						iss_q <= 1'b0;
						st_q  <= ST_FIN;
					end else if (iss_q && rd_idx_q == LAST_IDX) begin
						iss_q <= 1'b0;
					end
					if (eval) begin
						case (op_q)
							OP_CHECKIN: begin
								if (!slot_done) begin
									done_q <= 1'b0;
								end
								if (is_last) begin
									res_refresh_q <= done_q && slot_done;
								end
								if (is_last && done_q && slot_done) begin
									chk_q <= '0;
								end else if (hit) begin
									chk_q[idx_s1] <= 1'b1;
								end
							end
							OP_REGISTER: begin
								if (free) begin
									chk_q[idx_s1] <= 1'b0;
								end else if (is_last) begin
									res_status_q <= STAT_FULL;
								end
							end
							OP_UNREGISTER: begin
								if (hit) begin
									chk_q[idx_s1] <= 1'b0;
								end else if (is_last) begin
									res_status_q <= STAT_NOTFOUND;
								end
							end
							default: ;
						endcase
					end
				end
				ST_FIN: begin
					// hand result to the output register once it is free
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Key register, no reset needed
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid) begin
			key_q <= ID_BITS'(in_cid);
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_refresh_q <= res_refresh_q;
			out_status_q  <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - STAT_W - 1){1'b0}}, out_status_q, out_refresh_q};

`ifndef SYNTH
	// A refresh only ever goes out with an ok status
	a_refresh_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_refresh_q) |-> (out_status_q == STAT_OK))
		else $error("refresh with non-ok status");

	// Flags are all cleared by the time a refresh result is pending
	a_flags_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && res_refresh_q) |-> (chk_q == '0))
		else $error("check-in flags not cleared on refresh");

	// No read issue left running outside a scan
	a_no_stray_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !iss_q)
		else $error("read issue active while idle");

	// An accepted beat always starts a scan or finishes at once
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (st_q == ST_SCAN || st_q == ST_FIN))
		else $error("accepted beat did not leave idle");
`endif

endmodule

@@ sv/mcwd_slot_ram.sv @@
`timescale 1ns / 1ps
// Client id slot store: one write port, one registered read port.
// Per-entry valid bits make never-written slots read as id 0 (free).
module mcwd_slot_ram #(
	parameter int DEPTH = 24,
	parameter int AW    = 5,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    rd_s1;
	logic             rvld_s1;

	// Storage write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	// Written-since-reset marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_s1 <= vld_q[raddr];
		end
	end

	assign rdata = rvld_s1 ? rd_s1 : '0;

endmodule

@@ tb/multi_client_watchdog_checkin_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multi_client_watchdog_checkin_unit.
// Depends on mcwd_pkg and the unit itself. It keeps its own copy of the client table,
// predicts every reply and compares it with the master-side beats.
module multi_client_watchdog_checkin_unit_tb;
	import mcwd_pkg::*;

	localparam int SLOTS       = 24;
	localparam int ID_BITS     = 16;
	localparam int ITEM_TARGET = 720;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 40;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic    refresh;
		status_t status;
	} reply_t;

	// Client table copy and the queue of replies still due from the unit
	class checkin_table_model;
		logic [ID_BITS-1:0] slot_ids[SLOTS];
		bit                 slot_flag[SLOTS];
		reply_t             due_replies[$];
		int errors, replies_seen, kicks, fulls, absents;

		function new();
			foreach (slot_ids[i]) begin
				slot_ids[i]  = '0;
				slot_flag[i] = 1'b0;
			end
			errors = 0;
			replies_seen = 0;
			kicks = 0;
			fulls = 0;
			absents = 0;
		endfunction

		// Apply one accepted request to the table and queue its reply
		function void note_request(logic [OP_W-1:0] op, logic [ID_BITS-1:0] id);
			reply_t res;
			bit     all_done;
			bit     hit;
			res.refresh = 1'b0;
			res.status  = STAT_OK;
			all_done    = 1'b1;
			hit         = 1'b0;
			case (op)
				OP_CHECKIN: begin
					foreach (slot_ids[i]) begin
						if (slot_ids[i] == id)
							slot_flag[i] = 1'b1;
						if (slot_ids[i] != '0 && !slot_flag[i])
							all_done = 1'b0;
					end
					if (all_done) begin
						foreach (slot_flag[i])
							slot_flag[i] = 1'b0;
						res.refresh = 1'b1;
						kicks++;
					end
				end
				OP_REGISTER: begin
					foreach (slot_ids[i]) begin
						if (!hit && slot_ids[i] == '0) begin
							slot_ids[i]  = id;
							slot_flag[i] = 1'b0;
							hit = 1'b1;
						end
					end
					if (!hit) begin
						res.status = STAT_FULL;
						fulls++;
					end
				end
				OP_UNREGISTER: begin
					foreach (slot_ids[i]) begin
						if (!hit && slot_ids[i] == id) begin
							slot_ids[i]  = '0;
							slot_flag[i] = 1'b0;
							hit = 1'b1;
						end
					end
					if (!hit) begin
						res.status = STAT_NOTFOUND;
						absents++;
					end
				end
				default: ;
			endcase
			due_replies.push_back(res);
		endfunction

		// Compare one reply beat with the oldest prediction
		function void check_reply(logic [M_TDATA_W-1:0] beat);
			reply_t want;
			logic   got_refresh;
			logic [STAT_W-1:0] got_status;
			got_refresh = beat[0];
			got_status  = beat[STAT_W:1];
			replies_seen++;
			if (due_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply beat, expected none, actual %h", $time, beat);
				return;
			end
			want = due_replies.pop_front();
			if (got_refresh !== want.refresh) begin
				errors++;
				$display("%0t: refresh mismatch, expected %b, actual %b",
					$time, want.refresh, got_refresh);
			end
			if (got_status !== want.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want.status, got_status);
			end
		endfunction

		// Random occupied id, or zero when the table is empty
		function logic [ID_BITS-1:0] some_client();
			logic [ID_BITS-1:0] ids[$];
			foreach (slot_ids[i])
				if (slot_ids[i] != '0)
					ids.push_back(slot_ids[i]);
			if (ids.size() == 0)
				return '0;
			return ids[$urandom_range(ids.size() - 1)];
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic [S_TDATA_W-1:0] s_tdata;   // op [1:0], client_id [17:2], zero fill [23:18]
	logic                 s_tvalid;
	logic                 s_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // refresh [0], status [2:1], zero fill [7:3]
	logic                 m_tvalid;
	logic                 m_tready;

	checkin_table_model wd_table;
	logic [ID_BITS-1:0] id_pool[8];
	int items_sent;
	int requests_sent;
	int tx_gap_pct;
	int rx_stall_pct;
	int rx_stall_left;
	int cycles;

	multi_client_watchdog_checkin_unit #(
		.SLOTS  (SLOTS),
		.ID_BITS(ID_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata (m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run-length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("multi_client_watchdog_checkin_unit_tb failed");
			$finish;
		end
	end

	// Reply side: random back-pressure, mostly short stalls, a few long ones
	always @(negedge clk) begin
		if (rx_stall_left > 0) begin
			m_tready <= 1'b0;
			rx_stall_left--;
		end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
			m_tready <= 1'b0;
			rx_stall_left = ($urandom_range(7) == 0) ? $urandom_range(40, 15) - 1
				: $urandom_range(2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Reply monitor
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			wd_table.check_reply(m_tdata);

	function automatic int pick_gap();
		if (tx_gap_pct == 0 || $urandom_range(99) >= tx_gap_pct)
			return 0;
		if ($urandom_range(7) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [ID_BITS-1:0] pick_id();
		int r;
		logic [ID_BITS-1:0] id;
		r = $urandom_range(99);
		if (r < 45)
			return id_pool[$urandom_range(7)];
		if (r < 80) begin
			id = wd_table.some_client();
			return (id != '0) ? id : id_pool[$urandom_range(7)];
		end
		if (r < 97)
			return ID_BITS'($urandom_range(65535, 1));
		return '0;
	endfunction

	// Send one request beat; returns right after the edge that took it
	task automatic send_request(logic [OP_W-1:0] op, logic [ID_BITS-1:0] id);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - OP_W - CID_W){1'b0}}, id, op};
		do @(posedge clk); while (!s_tready);
		wd_table.note_request(op, id);
		requests_sent++;
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Hold off until every predicted reply has come back
	task automatic wait_replies();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (wd_table.due_replies.size() != 0)
			@(posedge clk);
	endtask

	// Check in every registered client in random order; each round gives at least one kick
	task automatic checkin_round();
		logic [ID_BITS-1:0] ids[$];
		logic [ID_BITS-1:0] tmp;
		int j;
		foreach (wd_table.slot_ids[i])
			if (wd_table.slot_ids[i] != '0)
				ids.push_back(wd_table.slot_ids[i]);
		for (int i = ids.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = ids[i];
			ids[i] = ids[j];
			ids[j] = tmp;
		end
		if (ids.size() == 0)
			send_request(OP_CHECKIN, pick_id());
		foreach (ids[i])
			send_request(OP_CHECKIN, ids[i]);
	endtask

	initial begin
		int len;
		int r;
		int kind;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		rx_stall_left = 0;
		rx_stall_pct = 0;
		tx_gap_pct = 0;
		items_sent = 0;
		requests_sent = 0;
		cycles = 0;
		wd_table = new();
		id_pool[0] = 16'hFFFF;
		id_pool[1] = 16'h0001;
		for (int i = 2; i < 8; i++)
			id_pool[i] = ID_BITS'($urandom_range(65535, 1));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty-table kicks, duplicates, absent ids, id zero, unused op
		send_request(OP_CHECKIN, 16'h0001);
		send_request(OP_CHECKIN, 16'h0000);
		send_request(OP_REGISTER, 16'hFFFF);
		send_request(OP_REGISTER, 16'h0001);
		send_request(OP_REGISTER, 16'h0001);
		send_request(OP_CHECKIN, 16'hFFFF);
		send_request(OP_CHECKIN, 16'h0001);
		send_request(OP_UNREGISTER, 16'h0001);
		send_request(OP_UNREGISTER, 16'h8000);
		send_request(OP_CHECKIN, 16'h0000);
		send_request(OP_UNUSED, 16'hAAAA);
		send_request(OP_UNUSED, 16'h5555);
		send_request(OP_REGISTER, 16'h0000);
		send_request(OP_UNREGISTER, 16'h0000);
		send_request(OP_CHECKIN, 16'h0001);
		send_request(OP_CHECKIN, 16'hFFFF);
		send_request(OP_UNREGISTER, 16'hFFFF);
		send_request(OP_UNREGISTER, 16'h0001);
		send_request(OP_UNREGISTER, 16'h0001);
		send_request(OP_REGISTER, 16'h5A5A);
		send_request(OP_REGISTER, 16'hA5A5);
		send_request(OP_CHECKIN, 16'hA5A5);
		send_request(OP_CHECKIN, 16'h5A5A);
		wait_replies();

		// Random phases: fill, check-in rounds, drain and a loose mix
		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(3);
			r = $urandom_range(2);
			tx_gap_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;
			r = $urandom_range(2);
			rx_stall_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;
			len = $urandom_range(60, 30);
			case (kind)
				0: repeat (len) begin
					r = $urandom_range(99);
					if (r < 75)
						send_request(OP_REGISTER, pick_id());
					else if (r < 90)
						send_request(OP_CHECKIN, pick_id());
					else if (r < 97)
						send_request(OP_UNREGISTER, pick_id());
					else
						send_request(OP_UNUSED, ID_BITS'($urandom_range(65535)));
				end
				1: repeat ($urandom_range(4, 1)) checkin_round();
				2: repeat (len) begin
					r = $urandom_range(99);
					if (r < 70)
						send_request(OP_UNREGISTER, pick_id());
					else if (r < 85)
						send_request(OP_CHECKIN, pick_id());
					else
						send_request(OP_REGISTER, pick_id());
				end
				default: repeat (len) begin
					r = $urandom_range(99);
					if (r < 5)
						send_request(OP_UNUSED, ID_BITS'($urandom_range(65535)));
					else
						send_request(logic'($urandom_range(2)) ? OP_REGISTER : OP_CHECKIN,
							pick_id());
				end
			endcase
			if (kind == 3 && $urandom_range(1) == 0)
				send_request(OP_UNREGISTER, pick_id());
			if ($urandom_range(3) == 0)
				wait_replies();
		end

		wait_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (wd_table.due_replies.size() != 0) begin
			wd_table.errors++;
			$display("%0t: replies missing, expected %0d more, actual 0",
				$time, wd_table.due_replies.size());
		end
		$display("Covered %0d requests and %0d replies: %0d watchdog kicks,",
			requests_sent, wd_table.replies_seen, wd_table.kicks);
		$display("%0d table-full and %0d unknown-id replies, %0d mismatches.",
			wd_table.fulls, wd_table.absents, wd_table.errors);
		if (wd_table.errors == 0)
			$display("multi_client_watchdog_checkin_unit_tb passed");
		else
			$display("multi_client_watchdog_checkin_unit_tb failed");
		$finish;
	end

endmodule
